/* rtl/csem_pkg.sv */
`default_nettype none
package csem_pkg;

    localparam int FUNC_W   = 2;
    localparam int TID_W    = 8;
    localparam int CNT_W    = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_WAIT   = 2'd0,
        FN_SIGNAL = 2'd1,
        FN_CLOSE  = 2'd2,
        FN_RSVD   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_ERROR   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ANSWER = 1'b0,
        KIND_WAKE   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    typedef enum logic [1:0] {
        M_NONE,
        M_SIGNAL,
        M_CLOSE
    } t_mode;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage
`default_nettype wire

/* rtl/csem_if.sv */
`default_nettype none
interface csem_in_if;
    import csem_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TID_W-1:0]    thread_id;
    logic [CNT_W-1:0]    count;

    modport source (output valid, func, thread_id, count, input ready);
    modport sink   (input valid, func, thread_id, count, output ready);
endinterface

interface csem_out_if;
    import csem_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [TID_W-1:0]    waker_thread;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, kind, waker_thread, status, last, input ready);
    modport sink   (input valid, kind, waker_thread, status, last, output ready);
endinterface
`default_nettype wire

/* rtl/csem_ram.sv */
`default_nettype none
module csem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/csem_alu.sv */
`default_nettype none
module csem_alu #(
    parameter int WIDTH = 16
) (
    input  wire csem_pkg::t_alu_op   i_op,
    input  wire logic [WIDTH-1:0]    i_a,
    input  wire logic [WIDTH-1:0]    i_b,
    output logic      [WIDTH-1:0]    o_res,
    output logic                     o_borrow
);
    import csem_pkg::*;

    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   sum;

    // One adder serves both operations; subtraction adds the complement plus one.
    always_comb begin
        b_eff = (i_op == ALU_SUB) ? ~i_b : i_b;
        sum   = {1'b0, i_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (i_op == ALU_SUB)};
        if (i_op == ALU_ADD && sum[WIDTH]) begin
            o_res = {WIDTH{1'b1}};
        end else begin
            o_res = sum[WIDTH-1:0];
        end
        o_borrow = (i_op == ALU_SUB) && !sum[WIDTH];
    end
endmodule
`default_nettype wire

/* rtl/csem_ctrl.sv */
`default_nettype none
module csem_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_BITS  = 16,
    parameter int THREAD_BITS = 8,
    parameter int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [csem_pkg::CNT_W-1:0]         i_cfg_wdata,
    csem_in_if.sink                                 i_req,
    csem_out_if.source                              o_rsp,
    output csem_pkg::t_alu_op                       o_alu_op,
    output logic [COUNT_BITS-1:0]                   o_alu_a,
    output logic [COUNT_BITS-1:0]                   o_alu_b,
    input  wire logic [COUNT_BITS-1:0]              i_alu_res,
    input  wire logic                               i_alu_borrow,
    output logic                                    o_ram_we,
    output logic [PTR_W-1:0]                        o_ram_waddr,
    output logic [THREAD_BITS+COUNT_BITS-1:0]       o_ram_wdata,
    output logic [PTR_W-1:0]                        o_ram_raddr,
    input  wire logic [THREAD_BITS+COUNT_BITS-1:0]  i_ram_rdata
);
    import csem_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_state                 r_state, n_state;
    t_mode                  r_mode, n_mode;
    t_func                  r_func;
    logic [THREAD_BITS-1:0] r_tid;
    logic [COUNT_BITS-1:0]  r_n;
    logic [COUNT_BITS-1:0]  r_units, n_units;
    logic                   r_open, n_open;
    logic [PTR_W-1:0]       r_head, n_head;
    logic [PTR_W-1:0]       r_tail, n_tail;
    logic [OCC_W-1:0]       r_occ, n_occ;
    t_kind                  r_pend_kind, n_pend_kind;
    logic [TID_W-1:0]       r_pend_thread, n_pend_thread;
    t_status                r_pend_status, n_pend_status;
    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    logic [TID_W-1:0]       r_out_thread, n_out_thread;
    t_status                r_out_status, n_out_status;
    logic                   r_out_last, n_out_last;

    logic                   accept;
    logic                   out_free;
    logic                   more;
    logic [THREAD_BITS-1:0] q_id;
    logic [COUNT_BITS-1:0]  q_need;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign q_id     = i_ram_rdata[THREAD_BITS+COUNT_BITS-1:COUNT_BITS];
    assign q_need   = i_ram_rdata[COUNT_BITS-1:0];

    // Another waiter is released when the queue holds one and either the
    // semaphore is closing or the head's need fits the held units.
    assign more = (r_state == S_WALK) && (r_occ != '0) &&
                  ((r_mode == M_CLOSE) || ((r_mode == M_SIGNAL) && !i_alu_borrow));

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_out_kind;
    assign o_rsp.waker_thread = r_out_thread;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.last         = r_out_last;

    // The queue entry at the next head is read every cycle, so the head's
    // word is ready when the walk looks at it.
    assign o_ram_raddr = n_head;
    assign o_ram_waddr = r_tail;
    assign o_ram_wdata = {r_tid, r_n};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (out_free && !more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_mode        = r_mode;
        n_units       = r_units;
        n_open        = r_open;
        n_head        = r_head;
        n_tail        = r_tail;
        n_occ         = r_occ;
        n_pend_kind   = r_pend_kind;
        n_pend_thread = r_pend_thread;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_kind    = r_out_kind;
        n_out_thread  = r_out_thread;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        o_ram_we      = 1'b0;
        o_alu_op      = ALU_SUB;
        o_alu_a       = r_units;
        o_alu_b       = q_need;

        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                o_alu_b       = r_n;
                o_alu_op      = (r_func == FN_SIGNAL) ? ALU_ADD : ALU_SUB;
                n_mode        = M_NONE;
                n_pend_kind   = KIND_ANSWER;
                n_pend_thread = TID_W'(r_tid);
                n_pend_status = ST_OK;
                if (!r_open) begin
                    n_pend_status = ST_ERROR;
                end else begin
                    unique case (r_func)
                        FN_WAIT: begin
                            if (r_n == '0) begin
                                n_pend_status = ST_OK;
                            end else if (!i_alu_borrow) begin
                                n_units = i_alu_res;
                            end else if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                                n_pend_status = ST_FULL;
                            end else begin
                                o_ram_we      = 1'b1;
                                n_tail        = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                '0 : r_tail + 1'b1;
                                n_occ         = r_occ + 1'b1;
                                n_pend_status = ST_BLOCKED;
                            end
                        end
                        FN_SIGNAL: begin
                            n_units = i_alu_res;
                            n_mode  = M_SIGNAL;
                        end
                        FN_CLOSE: begin
                            n_open = 1'b0;
                            n_mode = M_CLOSE;
                        end
                        FN_RSVD: begin
                            n_pend_status = ST_ERROR;
                        end
                        default: n_pend_status = ST_ERROR;
                    endcase
                end
            end
            S_WALK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_thread = r_pend_thread;
                    n_out_status = r_pend_status;
                    n_out_last   = !more;
                    if (more) begin
                        n_pend_kind   = KIND_WAKE;
                        n_pend_thread = TID_W'(q_id);
                        n_pend_status = (r_mode == M_CLOSE) ? ST_ERROR : ST_OK;
                        if (r_mode == M_SIGNAL) begin
                            n_units = i_alu_res;
                        end
                        n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        n_occ  = r_occ - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            n_units = COUNT_BITS'(i_cfg_wdata);
            n_open  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_NONE;
            r_units     <= '0;
            r_open      <= 1'b1;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_units     <= n_units;
            r_open      <= n_open;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_req.func);
            r_tid  <= THREAD_BITS'(i_req.thread_id);
            r_n    <= COUNT_BITS'(i_req.count);
        end
        r_pend_kind   <= n_pend_kind;
        r_pend_thread <= n_pend_thread;
        r_pend_status <= n_pend_status;
        r_out_kind    <= n_out_kind;
        r_out_thread  <= n_out_thread;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end
endmodule
`default_nettype wire

/* rtl/counting_semaphore_fifo_waiters.sv */
`default_nettype none
// Each request passes an execute state, which runs the operation on the shared adder, and
// a walk state, which presents the answer word once the result register is free.
// A signal or close then delivers one wake word per cycle while the consumer keeps up,
// limited by the adder compare on the head waiter and the one-read queue memory.
// A new request is accepted once the last word of the previous one is registered,
// so the block takes no new request while one is still executing or walking.
// Synchronous active-low reset empties the queue, reopens the semaphore and zeroes the units.
module counting_semaphore_fifo_waiters #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_BITS  = 16,
    parameter int THREAD_BITS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [csem_pkg::CNT_W-1:0] i_cfg_wdata,
    csem_in_if.sink                         i_req,
    csem_out_if.source                      o_rsp
);
    import csem_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ENT_W = THREAD_BITS + COUNT_BITS;

    t_alu_op               alu_op;
    logic [COUNT_BITS-1:0] alu_a;
    logic [COUNT_BITS-1:0] alu_b;
    logic [COUNT_BITS-1:0] alu_res;
    logic                  alu_borrow;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [PTR_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;

    csem_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_BITS  (COUNT_BITS),
        .THREAD_BITS (THREAD_BITS),
        .PTR_W       (PTR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .o_alu_op     (alu_op),
        .o_alu_a      (alu_a),
        .o_alu_b      (alu_b),
        .i_alu_res    (alu_res),
        .i_alu_borrow (alu_borrow),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    csem_alu #(
        .WIDTH (COUNT_BITS)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    csem_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csem_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int RAND_ITEMS = 243;
    localparam int N_ROWS     = 27;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  thread;
        t_status     status;
        logic        last;
    } sem_word_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] need;
    } waiter_t;

    typedef struct packed {
        t_func       f;
        logic [7:0]  tid;
        logic [15:0] n;
        logic        pinned;
        t_status     st;
    } op_row_t;

    // Rows with pinned set carry the answer status expected at that point in the sequence.
    op_row_t op_rows [0:N_ROWS-1] = '{
        '{FN_WAIT,   8'h00, 16'h0000, 1'b1, ST_OK},
        '{FN_WAIT,   8'hFF, 16'h0001, 1'b1, ST_BLOCKED},
        '{FN_SIGNAL, 8'h01, 16'hFFFF, 1'b0, ST_OK},
        '{FN_SIGNAL, 8'h02, 16'hFFFF, 1'b0, ST_OK},
        '{FN_WAIT,   8'h03, 16'hFFFF, 1'b0, ST_OK},
        '{FN_RSVD,   8'h04, 16'hAAAA, 1'b1, ST_ERROR},
        '{FN_WAIT,   8'h10, 16'h0001, 1'b0, ST_OK},
        '{FN_WAIT,   8'h21, 16'h0002, 1'b0, ST_OK},
        '{FN_WAIT,   8'h42, 16'h0003, 1'b0, ST_OK},
        '{FN_WAIT,   8'h83, 16'h0004, 1'b0, ST_OK},
        '{FN_WAIT,   8'h14, 16'h5555, 1'b0, ST_OK},
        '{FN_WAIT,   8'h25, 16'h0001, 1'b0, ST_OK},
        '{FN_WAIT,   8'h46, 16'h0002, 1'b0, ST_OK},
        '{FN_WAIT,   8'h87, 16'hFFFF, 1'b0, ST_OK},
        '{FN_WAIT,   8'h18, 16'h8000, 1'b0, ST_OK},
        '{FN_WAIT,   8'h29, 16'h0010, 1'b0, ST_OK},
        '{FN_WAIT,   8'h4A, 16'h0100, 1'b0, ST_OK},
        '{FN_WAIT,   8'h8B, 16'h1000, 1'b0, ST_OK},
        '{FN_WAIT,   8'h1C, 16'h00FF, 1'b0, ST_OK},
        '{FN_WAIT,   8'h2D, 16'h7FFF, 1'b0, ST_OK},
        '{FN_WAIT,   8'h4E, 16'h0005, 1'b0, ST_OK},
        '{FN_WAIT,   8'h8F, 16'h0006, 1'b0, ST_OK},
        '{FN_WAIT,   8'hC0, 16'h0001, 1'b1, ST_FULL},
        '{FN_SIGNAL, 8'h05, 16'h000A, 1'b0, ST_OK},
        '{FN_CLOSE,  8'h06, 16'h1234, 1'b0, ST_OK},
        '{FN_WAIT,   8'h07, 16'h0000, 1'b1, ST_ERROR},
        '{FN_CLOSE,  8'h08, 16'h0000, 1'b1, ST_ERROR}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    csem_in_if  req_if ();
    csem_out_if rsp_if ();

    counting_semaphore_fifo_waiters #(
        .QUEUE_DEPTH (QDEPTH),
        .COUNT_BITS  (16),
        .THREAD_BITS (8)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Shadow state of the semaphore.
    logic [15:0] sem_units;
    bit          sem_open;
    waiter_t     waiters[$];
    sem_word_t   words_due[$];

    int  mismatches = 0;
    int  rsp_words  = 0;
    bit  calm       = 1'b0;
    bit  in_flow    = 1'b0;
    bit  held       = 1'b0;
    int  hold_left  = 0;
    logic    pin_on;
    t_status pin_st;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Works out the words that one accepted operation must produce.
    function automatic void predict_op(t_func f, logic [7:0] tid, logic [15:0] n,
                                       logic pinned, t_status pinned_st);
        sem_word_t batch[$];
        t_status   answer;
        logic [16:0] sum;
        answer = ST_OK;
        batch.push_back('{KIND_ANSWER, tid, ST_OK, 1'b0});
        if (!sem_open || f == FN_RSVD) begin
            answer = ST_ERROR;
        end else begin
            case (f)
                FN_WAIT: begin
                    if (n == 16'd0) begin
                        answer = ST_OK;
                    end else if (sem_units >= n) begin
                        sem_units = sem_units - n;
                    end else if (waiters.size() >= QDEPTH) begin
                        answer = ST_FULL;
                    end else begin
                        waiters.push_back('{tid, n});
                        answer = ST_BLOCKED;
                    end
                end
                FN_SIGNAL: begin
                    sum = {1'b0, sem_units} + {1'b0, n};
                    sem_units = sum[16] ? 16'hFFFF : sum[15:0];
                    while (waiters.size() > 0 && waiters[0].need <= sem_units) begin
                        sem_units = sem_units - waiters[0].need;
                        batch.push_back('{KIND_WAKE, waiters[0].id, ST_OK, 1'b0});
                        void'(waiters.pop_front());
                    end
                end
                default: begin
                    sem_open = 1'b0;
                    while (waiters.size() > 0) begin
                        batch.push_back('{KIND_WAKE, waiters[0].id, ST_ERROR, 1'b0});
                        void'(waiters.pop_front());
                    end
                end
            endcase
        end
        batch[0].status = pinned ? pinned_st : answer;
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) words_due.push_back(batch[i]);
    endfunction

    always @(posedge i_clk) begin
        sem_word_t want;
        if (!i_rst_n) begin
            sem_units = 16'd0;
            sem_open  = 1'b1;
            waiters.delete();
        end else begin
            if (i_cfg_we) begin
                sem_units = i_cfg_wdata;
                sem_open  = 1'b1;
            end
            if (req_if.valid && req_if.ready)
                predict_op(t_func'(req_if.func), req_if.thread_id, req_if.count,
                           pin_on, pin_st);
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_words++;
                if (words_due.size() == 0) begin
                    $error("word with nothing expected: thread %0d status %0d",
                           rsp_if.waker_thread, rsp_if.status);
                    mismatches++;
                end else begin
                    want = words_due.pop_front();
                    if (rsp_if.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, rsp_if.kind);
                        mismatches++;
                    end
                    if (rsp_if.waker_thread !== want.thread) begin
                        $error("waker_thread: expected %0d, got %0d",
                               want.thread, rsp_if.waker_thread);
                        mismatches++;
                    end
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        mismatches++;
                    end
                    if (rsp_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Consumer side; once in the run it holds off long enough to back the block up.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!held && in_flow && rsp_words >= 150) begin
                held = 1'b1;
                hold_left = 300;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    task automatic offer_op(t_func f, logic [7:0] tid, logic [15:0] n,
                            logic pinned, t_status pinned_st);
        while (!calm && $urandom_range(99) < 17) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= f;
        req_if.thread_id <= tid;
        req_if.count     <= n;
        pin_on           <= pinned;
        pin_st           <= pinned_st;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // The register is only written once every word of earlier operations is out.
    // The first edge lets the predictor take in an operation accepted just before.
    task automatic load_count(logic [15:0] v);
        @(posedge i_clk);
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase;
        int span;
        int r;
        t_func f;
        logic [15:0] n;
        logic [15:0] v;
        req_if.valid     = 1'b0;
        req_if.func      = FN_WAIT;
        req_if.thread_id = '0;
        req_if.count     = '0;
        pin_on           = 1'b0;
        pin_st           = ST_OK;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_rst_n          = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++)
            offer_op(op_rows[i].f, op_rows[i].tid, op_rows[i].n,
                     op_rows[i].pinned, op_rows[i].st);
        req_if.valid <= 1'b0;

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            in_flow = 1'b0;
            case (phase)
                0:       v = 16'h0000;
                1:       v = 16'hFFFF;
                2:       v = 16'(2 * $urandom_range(10));
                default: begin
                    r = $urandom_range(3);
                    v = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                        (r == 2) ? 16'($urandom_range(20)) : 16'($urandom);
                end
            endcase
            load_count(v);
            calm    = (phase == 3);
            in_flow = 1'b1;
            span = $urandom_range(50, 20);
            for (int k = 0; k < span && sent < RAND_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 55) f = FN_WAIT;
                else if (r < 95) f = FN_SIGNAL;
                else if (r < 97) f = FN_RSVD;
                else f = FN_CLOSE;
                r = $urandom_range(99);
                if (f == FN_WAIT)
                    n = (r < 70) ? 16'($urandom_range(6, 1)) : (r < 80) ? 16'h0000 :
                        (r < 90) ? 16'($urandom) : 16'hFFFF;
                else
                    n = (r < 75) ? 16'($urandom_range(8, 1)) : (r < 90) ? 16'($urandom) :
                        (r < 95) ? 16'h0000 : 16'hFFFF;
                offer_op(f, 8'($urandom_range(255)), n, 1'b0, ST_OK);
                sent++;
            end
            req_if.valid <= 1'b0;
            phase++;
        end
        in_flow = 1'b0;
        calm    = 1'b0;

        @(posedge i_clk);
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #3_600_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/csem_pkg.sv
rtl/csem_if.sv
rtl/csem_ram.sv
rtl/csem_alu.sv
rtl/csem_ctrl.sv
rtl/counting_semaphore_fifo_waiters.sv
test/tb.sv
